// ===== sv/otw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and default parameters of the one-shot timer wheel.
package otw_pkg;

    localparam int WHEEL_SLOTS_DEF = 256;
    localparam int TICK_MS_DEF     = 10;
    localparam int SLOT_DEPTH_DEF  = 8;

    localparam int TASK_W     = 8;
    localparam int DELAY_W    = 16;
    localparam int KIND_W     = 3;
    localparam int TICK_OUT_W = 9;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED    = 3'd0,
        KIND_IDLE     = 3'd1,
        KIND_ADDED    = 3'd2,
        KIND_LATE     = 3'd3,
        KIND_FULL     = 3'd4,
        KIND_FINISHED = 3'd5,
        KIND_STOPPED  = 3'd6
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic  clr_wr;
        logic  latch_in;
        logic  mul_en;
        logic  tick_adv;
        logic  fill_rd_tick;
        logic  fill_rd_add;
        logic  add_commit;
        logic  fire_start;
        logic  task_rd;
        logic  fire_load;
        logic  emit_load;
        kind_t kind;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_add;
        logic done;
        logic tick_end;
        logic late;
        logic full;
        logic fill_zero;
        logic count_one;
        logic out_free;
    } status_t;

endpackage

// ===== sv/otw_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module otw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/otw_datapath.sv =====
`timescale 1ns / 1ps
// Timer wheel datapath: tick state, slot arithmetic, slot RAMs and result register.
module otw_datapath #(
    parameter int WHEEL_SLOTS = otw_pkg::WHEEL_SLOTS_DEF,
    parameter int TICK_MS     = otw_pkg::TICK_MS_DEF,
    parameter int SLOT_DEPTH  = otw_pkg::SLOT_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  otw_pkg::cmd_t                 cmd,
    output otw_pkg::status_t              status,
    input  logic                          s_opcode,
    input  logic [otw_pkg::TASK_W-1:0]    s_task_id,
    input  logic [otw_pkg::DELAY_W-1:0]   s_delay_ms,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [otw_pkg::KIND_W-1:0]    m_kind,
    output logic [otw_pkg::TASK_W-1:0]    m_fired_task,
    output logic [otw_pkg::TICK_OUT_W-1:0] m_tick_now,
    output logic                          m_last_of_run
);

    localparam int SLOT_W     = $clog2(WHEEL_SLOTS);
    localparam int TICK_W     = $clog2(WHEEL_SLOTS + 1);
    localparam int FILL_W     = $clog2(SLOT_DEPTH + 1);
    localparam int IDX_W      = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int TASK_DEPTH = WHEEL_SLOTS << IDX_W;
    localparam int SUM_W      = otw_pkg::DELAY_W + 1;
    // delay / TICK_MS as a multiply by a rounded-up reciprocal; exact for 16-bit delays
    localparam int DIV_SHIFT  = otw_pkg::DELAY_W + $clog2(TICK_MS);
    localparam int DIV_MULT   = ((1 << DIV_SHIFT) + TICK_MS - 1) / TICK_MS;
    localparam int MULT_W     = otw_pkg::DELAY_W + 2;
    localparam int PROD_W     = otw_pkg::DELAY_W + MULT_W;
    localparam int EXT_W      = TICK_W + otw_pkg::TICK_OUT_W;
    localparam logic [MULT_W-1:0] MULT_C = MULT_W'(DIV_MULT);

    logic                         opcode_reg;
    logic [otw_pkg::TASK_W-1:0]   task_reg;
    logic [otw_pkg::DELAY_W-1:0]  delay_reg;
    logic [PROD_W-1:0]            product_reg;
    logic [TICK_W-1:0]            tick_reg;
    logic                         done_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [FILL_W-1:0]            count_reg;
    logic [SLOT_W-1:0]            clr_addr_reg;
    logic                         out_valid_reg;
    otw_pkg::kind_t               out_kind_reg;
    logic [otw_pkg::TASK_W-1:0]   out_task_reg;
    logic [otw_pkg::TICK_OUT_W-1:0] out_tick_reg;
    logic                         out_last_reg;

    logic [PROD_W-1:0]            prod_shift;
    logic [otw_pkg::DELAY_W-1:0]  quotient;
    logic [SUM_W-1:0]             slot_sum;
    logic [SLOT_W-1:0]            slot_sel;
    logic [TICK_W-1:0]            tick_inc;
    logic [FILL_W-1:0]            count_dec;
    logic [EXT_W-1:0]             tick_ext;

    logic                         fill_we;
    logic [SLOT_W-1:0]            fill_waddr;
    logic [FILL_W-1:0]            fill_wdata;
    logic                         fill_re;
    logic [SLOT_W-1:0]            fill_raddr;
    logic [FILL_W-1:0]            fill_rdata;
    logic [otw_pkg::TASK_W-1:0]   task_rdata;

    assign prod_shift = product_reg >> DIV_SHIFT;
    assign quotient   = prod_shift[otw_pkg::DELAY_W-1:0];
    assign slot_sum   = SUM_W'(quotient) + SUM_W'(tick_reg);
    assign slot_sel   = slot_sum[SLOT_W-1:0];
    assign tick_inc   = tick_reg + 1'b1;
    assign count_dec  = count_reg - 1'b1;
    assign tick_ext   = {{otw_pkg::TICK_OUT_W{1'b0}}, tick_reg};

    // fill RAM: one write port shared by clearing, add and slot flush
    always_comb begin
        fill_we    = cmd.clr_wr | cmd.add_commit | cmd.fire_start;
        fill_waddr = clr_addr_reg;
        fill_wdata = '0;
        if (cmd.add_commit) begin
            fill_waddr = slot_reg;
            fill_wdata = fill_rdata + 1'b1;
        end else if (cmd.fire_start) begin
            fill_waddr = tick_reg[SLOT_W-1:0];
        end
        fill_re    = cmd.fill_rd_add | cmd.fill_rd_tick;
        fill_raddr = cmd.fill_rd_add ? slot_sel : tick_inc[SLOT_W-1:0];
    end

    otw_ram #(
        .WIDTH (FILL_W),
        .DEPTH (WHEEL_SLOTS)
    ) u_fill_ram (
        .aclk  (aclk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (fill_re),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    otw_ram #(
        .WIDTH (otw_pkg::TASK_W),
        .DEPTH (TASK_DEPTH)
    ) u_task_ram (
        .aclk  (aclk),
        .we    (cmd.add_commit),
        .waddr ({slot_reg, fill_rdata[IDX_W-1:0]}),
        .wdata (task_reg),
        .re    (cmd.task_rd),
        .raddr ({tick_reg[SLOT_W-1:0], count_dec[IDX_W-1:0]}),
        .rdata (task_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            done_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.tick_adv) begin
                tick_reg <= tick_inc;
                if (tick_reg == TICK_W'(WHEEL_SLOTS - 1)) begin
                    done_reg <= 1'b1;
                end
            end
            if (cmd.fire_load || cmd.emit_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            opcode_reg <= s_opcode;
            task_reg   <= s_task_id;
            delay_reg  <= s_delay_ms;
        end
        if (cmd.mul_en) begin
            product_reg <= PROD_W'(delay_reg) * PROD_W'(MULT_C);
        end
        if (cmd.fill_rd_add) begin
            slot_reg <= slot_sel;
        end
        if (cmd.fire_start) begin
            count_reg <= fill_rdata;
        end else if (cmd.fire_load) begin
            count_reg <= count_dec;
        end
        if (cmd.fire_load) begin
            out_kind_reg <= otw_pkg::KIND_FIRED;
            out_task_reg <= task_rdata;
            out_tick_reg <= tick_ext[otw_pkg::TICK_OUT_W-1:0];
            out_last_reg <= (count_reg == FILL_W'(1));
        end else if (cmd.emit_load) begin
            out_kind_reg <= cmd.kind;
            out_task_reg <= '0;
            out_tick_reg <= tick_ext[otw_pkg::TICK_OUT_W-1:0];
            out_last_reg <= 1'b1;
        end
    end

    always_comb begin
        status.clr_last  = (clr_addr_reg == SLOT_W'(WHEEL_SLOTS - 1));
        status.is_add    = (opcode_reg == otw_pkg::OP_ADD);
        status.done      = done_reg;
        status.tick_end  = (tick_reg == TICK_W'(WHEEL_SLOTS - 1));
        status.late      = (slot_sum >= SUM_W'(WHEEL_SLOTS));
        status.full      = (fill_rdata >= FILL_W'(SLOT_DEPTH));
        status.fill_zero = (fill_rdata == '0);
        status.count_one = (count_reg == FILL_W'(1));
        status.out_free  = !out_valid_reg || m_ready;
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_kind_reg;
    assign m_fired_task  = out_task_reg;
    assign m_tick_now    = out_tick_reg;
    assign m_last_of_run = out_last_reg;

endmodule

// ===== sv/otw_ctrl.sv =====
`timescale 1ns / 1ps
// Timer wheel controller: sequences clearing, add, tick and firing.
module otw_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  otw_pkg::status_t status,
    output otw_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SLOT,
        S_AFILL,
        S_TFILL,
        S_FRD,
        S_FOUT,
        S_EMIT
    } state_t;

    state_t         state_reg, state_next;
    otw_pkg::kind_t kind_reg, kind_next;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        s_ready    = (state_reg == S_IDLE);
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (status.done) begin
                    kind_next  = otw_pkg::KIND_STOPPED;
                    state_next = S_EMIT;
                end else if (status.is_add) begin
                    cmd.mul_en = 1'b1;
                    state_next = S_SLOT;
                end else if (status.tick_end) begin
                    cmd.tick_adv = 1'b1;
                    kind_next    = otw_pkg::KIND_FINISHED;
                    state_next   = S_EMIT;
                end else begin
                    cmd.tick_adv     = 1'b1;
                    cmd.fill_rd_tick = 1'b1;
                    state_next       = S_TFILL;
                end
            end
            S_SLOT: begin
                if (status.late) begin
                    kind_next  = otw_pkg::KIND_LATE;
                    state_next = S_EMIT;
                end else begin
                    cmd.fill_rd_add = 1'b1;
                    state_next      = S_AFILL;
                end
            end
            S_AFILL: begin
                if (status.full) begin
                    kind_next = otw_pkg::KIND_FULL;
                end else begin
                    cmd.add_commit = 1'b1;
                    kind_next      = otw_pkg::KIND_ADDED;
                end
                state_next = S_EMIT;
            end
            S_TFILL: begin
                if (status.fill_zero) begin
                    kind_next  = otw_pkg::KIND_IDLE;
                    state_next = S_EMIT;
                end else begin
                    cmd.fire_start = 1'b1;
                    state_next     = S_FRD;
                end
            end
            S_FRD: begin
                cmd.task_rd = 1'b1;
                state_next  = S_FOUT;
            end
            S_FOUT: begin
                if (status.out_free) begin
                    cmd.fire_load = 1'b1;
                    state_next    = status.count_one ? S_IDLE : S_FRD;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            kind_reg  <= otw_pkg::KIND_IDLE;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// ===== sv/one_shot_timer_wheel_core.sv =====
`timescale 1ns / 1ps
// Top level of the one-shot single-level timer wheel.
//
// One-shot timer wheel with WHEEL_SLOTS slots of up to SLOT_DEPTH task ids
// each. An add transaction (opcode 1) places task_id in slot
// delay_ms / TICK_MS + current tick and answers added, too late (slot past
// the wheel) or slot full. A tick transaction (opcode 0) advances the tick;
// it answers idle when the new slot is empty, otherwise one fired result per
// stored task, newest first, with last_of_run on the final one, and empties
// the slot. The tick that reaches WHEEL_SLOTS answers finished, and every
// later transaction answers stopped. Every result carries the tick count
// after its transaction. The block takes one input transaction at a time:
// an add multiplies the delay, checks the slot for lateness, reads its fill
// and then stores the task or reports full before it answers; a tick
// advances and reads the new slot's fill, then for each fired task reads the
// task RAM and loads the output register. The slot fill RAM and the task RAM
// both have a registered read, so read data is used only in a later state.
// Results leave through an output register, so a new transaction is
// accepted while the previous result still waits for m_ready; a full
// output register stalls only the emission of the next result. After
// reset the fill RAM is cleared one slot per cycle; s_ready stays low until
// every slot is cleared.
module one_shot_timer_wheel_core #(
    parameter int WHEEL_SLOTS = otw_pkg::WHEEL_SLOTS_DEF,
    parameter int TICK_MS     = otw_pkg::TICK_MS_DEF,
    parameter int SLOT_DEPTH  = otw_pkg::SLOT_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [otw_pkg::TASK_W-1:0]     s_task_id,
    input  logic [otw_pkg::DELAY_W-1:0]    s_delay_ms,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [otw_pkg::KIND_W-1:0]     m_kind,
    output logic [otw_pkg::TASK_W-1:0]     m_fired_task,
    output logic [otw_pkg::TICK_OUT_W-1:0] m_tick_now,
    output logic                           m_last_of_run
);

    otw_pkg::cmd_t    cmd;
    otw_pkg::status_t status;

    // sequencer: owns the handshake on the input side
    otw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // storage, slot arithmetic and the result register
    otw_datapath #(
        .WHEEL_SLOTS (WHEEL_SLOTS),
        .TICK_MS     (TICK_MS),
        .SLOT_DEPTH  (SLOT_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_opcode      (s_opcode),
        .s_task_id     (s_task_id),
        .s_delay_ms    (s_delay_ms),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_kind        (m_kind),
        .m_fired_task  (m_fired_task),
        .m_tick_now    (m_tick_now),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== sv/otw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the timer wheel core, with its bind.
module otw_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [otw_pkg::KIND_W-1:0]     m_kind,
    input logic [otw_pkg::TASK_W-1:0]     m_fired_task,
    input logic [otw_pkg::TICK_OUT_W-1:0] m_tick_now,
    input logic                           m_last_of_run
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_fired_task)
            && $stable(m_tick_now) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    // only a fired result can be followed by more results of the same transaction
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != otw_pkg::KIND_FIRED) |-> m_last_of_run)
        else $error("non-fired result without last mark");

    a_task_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != otw_pkg::KIND_FIRED) |-> (m_fired_task == '0))
        else $error("task id on a non-fired result");

    // one transaction in flight: no back-to-back acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted in consecutive cycles");

endmodule

bind one_shot_timer_wheel_core otw_checker u_otw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_fired_task  (m_fired_task),
    .m_tick_now    (m_tick_now),
    .m_last_of_run (m_last_of_run)
);
